// ===== hw/rtl/radar_measurement_jacobian_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radar measurement Jacobian core
// Concurrent checks, with and without the reset gate.
// ----------------------------------------------------------------------------
`ifndef RADAR_MEASUREMENT_JACOBIAN_CORE_ASSERT_SVH
`define RADAR_MEASUREMENT_JACOBIAN_CORE_ASSERT_SVH

// Check a property outside of reset
`define RMJ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define RMJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rmj_pkg.sv =====
// ----------------------------------------------------------------------------
// rmj_pkg
// Widths and latencies shared by the radar measurement Jacobian core.
// ----------------------------------------------------------------------------
package rmj_pkg;

  // Field format
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;

  // Derived datapath widths
  localparam int PROD_W = 2 * DATA_W;          // squares and cross products
  localparam int ROOT_W = DATA_W;              // integer square root of PROD_W
  localparam int REM_W  = ROOT_W + 2;          // square root partial remainder
  localparam int QUO_W  = DATA_W;              // quotient bits before saturation
  localparam int DEN_W  = PROD_W + ROOT_W;     // widest divisor: C * R
  localparam int NUM_W  = PROD_W + DATA_W + FRAC_BITS; // widest dividend

  // Latencies of the iterative units, one bit per stage
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = QUO_W + 1;

  // Register stages from input register to output register, both included
  localparam int PIPE_DEPTH = 5 + SQRT_LAT + 2 + DIV_LAT + 1;

  localparam logic [DATA_W-1:0] MIN_RANGE_SQ_RESET = DATA_W'(7);

endpackage

// ===== hw/rtl/radar_measurement_jacobian_core.sv =====
// ----------------------------------------------------------------------------
// radar_measurement_jacobian_core
// Jacobian of range, bearing and range rate for a constant-velocity state.
// ----------------------------------------------------------------------------
// Usage:
//   Input request: pos_x_i, pos_y_i, vel_x_i, vel_y_i (signed fixed point),
//   taken when valid_i is high and stall_o is low.
//   Output request: six Jacobian entries and range_error_o, taken when
//   valid_o is high and stall_i is low.
//   cfg_we_i writes cfg_wdata_i into the minimum range squared threshold;
//   write it only while no request is in flight.
// Timing:
//   One request per cycle while stall_o is low. The pipeline depth is set
//   by the 32 stage square root and the 33 stage dividers, one result bit
//   per stage.
// Reset: the pipeline empties and the threshold returns to 7.
// Stall: while the output register holds an untaken result and stall_i is
//   high, every stage holds and stall_o is raised; nothing is dropped.
// ----------------------------------------------------------------------------
module radar_measurement_jacobian_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rmj_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic signed [rmj_pkg::DATA_W-1:0] pos_x_i,
  input  logic signed [rmj_pkg::DATA_W-1:0] pos_y_i,
  input  logic signed [rmj_pkg::DATA_W-1:0] vel_x_i,
  input  logic signed [rmj_pkg::DATA_W-1:0] vel_y_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic signed [rmj_pkg::DATA_W-1:0] drange_dx_o,
  output logic signed [rmj_pkg::DATA_W-1:0] drange_dy_o,
  output logic signed [rmj_pkg::DATA_W-1:0] dbearing_dx_o,
  output logic signed [rmj_pkg::DATA_W-1:0] dbearing_dy_o,
  output logic signed [rmj_pkg::DATA_W-1:0] drate_dx_o,
  output logic signed [rmj_pkg::DATA_W-1:0] drate_dy_o,
  output logic                              range_error_o
);
  import rmj_pkg::*;

  `include "radar_measurement_jacobian_core_assert.svh"

  localparam int NUM_ENT = 6;
  localparam int ENT_DRANGE_DX   = 0;
  localparam int ENT_DRANGE_DY   = 1;
  localparam int ENT_DBEARING_DX = 2;
  localparam int ENT_DBEARING_DY = 3;
  localparam int ENT_DRATE_DX    = 4;
  localparam int ENT_DRATE_DY    = 5;
  localparam int HALF_W          = PROD_W / 2;

  localparam logic [DATA_W:0] LIM_POS = {2'b00, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W:0] LIM_NEG = {2'b01, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [PROD_W-1:0]         c;
    logic [DATA_W-1:0]         ax;
    logic [DATA_W-1:0]         ay;
    logic [PROD_W+DATA_W-1:0]  axk;
    logic [PROD_W+DATA_W-1:0]  ayk;
    logic                      nx;
    logic                      ny;
    logic                      nk;
    logic                      err;
  } side_t;

  typedef struct packed {
    logic [NUM_ENT-1:0] neg;
    logic               err;
  } flag_t;

  // Clamp a quotient to the signed range, apply the sign, zero it on range error
  function automatic logic [DATA_W-1:0] sat_entry(input logic [QUO_W-1:0] q,
                                                  input logic ovf, input logic neg,
                                                  input logic err);
    logic [DATA_W:0] lim;
    logic [DATA_W:0] mag;
    logic [DATA_W:0] res;
    lim = neg ? LIM_NEG : LIM_POS;
    mag = (ovf || ({1'b0, q} > lim)) ? lim : {1'b0, q};
    res = neg ? (~mag + 1'b1) : mag;
    return err ? '0 : res[DATA_W-1:0];
  endfunction

  // Handshake and valid tracking
  logic                  en;
  logic                  accept;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [DATA_W-1:0]     min_rsq_q;

  assign stall_o = vld_q[PIPE_DEPTH-1] && stall_i;
  assign en      = !stall_o;
  assign accept  = valid_i && !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      min_rsq_q <= MIN_RANGE_SQ_RESET;
    end else begin
      if (en) begin
        vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
      end
      if (cfg_we_i) begin
        min_rsq_q <= cfg_wdata_i;
      end
    end
  end

  // Stage 1: input register
  logic signed [DATA_W-1:0] x1_q, y1_q, vx1_q, vy1_q;
  // Stage 2: products and magnitudes
  logic signed [PROD_W-1:0] xx2_q, yy2_q, p12_q, p22_q;
  logic [DATA_W-1:0]        ax2_q, ay2_q;
  logic                     nx2_q, ny2_q;
  // Stage 3: range squared, cross term, threshold
  logic [PROD_W-1:0]        c3_q, k3_q;
  logic [DATA_W-1:0]        ax3_q, ay3_q;
  logic                     nx3_q, ny3_q, nk3_q, err3_q;
  logic [PROD_W-1:0]        c3_d, thr3;
  // Stage 4: cross term partial products
  logic [PROD_W-1:0]        axl4_q, axh4_q, ayl4_q, ayh4_q, c4_q;
  logic [DATA_W-1:0]        ax4_q, ay4_q;
  logic                     nx4_q, ny4_q, nk4_q, err4_q;
  // Stage 5: side data entering the square root
  side_t                    s5_q;
  side_t                    side_q [SQRT_LAT];
  logic [ROOT_W-1:0]        root;
  // Stage 6 and 7: C * R in two halves
  logic [PROD_W-1:0]        crl6_q, crh6_q;
  logic [ROOT_W-1:0]        r6_q, r7_q;
  side_t                    s6_q, s7_q;
  logic [DEN_W-1:0]         cr7_q;

  always_comb begin
    c3_d = PROD_W'(xx2_q) + PROD_W'(yy2_q);
    thr3 = PROD_W'(min_rsq_q) << FRAC_BITS;
  end

  // Advance the front stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= pos_x_i;
      y1_q  <= pos_y_i;
      vx1_q <= vel_x_i;
      vy1_q <= vel_y_i;

      xx2_q <= x1_q * x1_q;
      yy2_q <= y1_q * y1_q;
      p12_q <= vx1_q * y1_q;
      p22_q <= vy1_q * x1_q;
      ax2_q <= x1_q[DATA_W-1] ? DATA_W'(-x1_q) : DATA_W'(x1_q);
      ay2_q <= y1_q[DATA_W-1] ? DATA_W'(-y1_q) : DATA_W'(y1_q);
      nx2_q <= x1_q[DATA_W-1];
      ny2_q <= y1_q[DATA_W-1];

      c3_q   <= c3_d;
      err3_q <= (c3_d == '0) || (c3_d < thr3);
      nk3_q  <= p12_q < p22_q;
      k3_q   <= (p12_q < p22_q) ? PROD_W'(p22_q - p12_q) : PROD_W'(p12_q - p22_q);
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      nx3_q  <= nx2_q;
      ny3_q  <= ny2_q;

      axl4_q <= ax3_q * k3_q[HALF_W-1:0];
      axh4_q <= ax3_q * k3_q[PROD_W-1:HALF_W];
      ayl4_q <= ay3_q * k3_q[HALF_W-1:0];
      ayh4_q <= ay3_q * k3_q[PROD_W-1:HALF_W];
      c4_q   <= c3_q;
      ax4_q  <= ax3_q;
      ay4_q  <= ay3_q;
      nx4_q  <= nx3_q;
      ny4_q  <= ny3_q;
      nk4_q  <= nk3_q;
      err4_q <= err3_q;

      s5_q.c   <= c4_q;
      s5_q.ax  <= ax4_q;
      s5_q.ay  <= ay4_q;
      s5_q.axk <= ((PROD_W+DATA_W)'(axh4_q) << HALF_W) + (PROD_W+DATA_W)'(axl4_q);
      s5_q.ayk <= ((PROD_W+DATA_W)'(ayh4_q) << HALF_W) + (PROD_W+DATA_W)'(ayl4_q);
      s5_q.nx  <= nx4_q;
      s5_q.ny  <= ny4_q;
      s5_q.nk  <= nk4_q;
      s5_q.err <= err4_q;
    end
  end

  // Square root of range squared
  rmj_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s5_q.c),
    .root_o (root)
  );

  // Delay side data alongside the square root
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= s5_q;
      for (int i = 1; i < SQRT_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Form C * R from two half products
  always_ff @(posedge clk_i) begin
    if (en) begin
      crl6_q <= side_q[SQRT_LAT-1].c[HALF_W-1:0] * root;
      crh6_q <= side_q[SQRT_LAT-1].c[PROD_W-1:HALF_W] * root;
      r6_q   <= root;
      s6_q   <= side_q[SQRT_LAT-1];

      cr7_q  <= (DEN_W'(crh6_q) << HALF_W) + DEN_W'(crl6_q);
      r7_q   <= r6_q;
      s7_q   <= s6_q;
    end
  end

  // Dividend, divisor and sign of each entry
  logic [NUM_W-1:0]   div_num [NUM_ENT];
  logic [DEN_W-1:0]   div_den [NUM_ENT];
  logic [QUO_W-1:0]   div_quo [NUM_ENT];
  logic               div_ovf [NUM_ENT];
  flag_t              flg7;
  flag_t              flg_q [DIV_LAT];

  always_comb begin
    div_num[ENT_DRANGE_DX]   = NUM_W'(s7_q.ax) << FRAC_BITS;
    div_num[ENT_DRANGE_DY]   = NUM_W'(s7_q.ay) << FRAC_BITS;
    div_num[ENT_DBEARING_DX] = NUM_W'(s7_q.ay) << (2 * FRAC_BITS);
    div_num[ENT_DBEARING_DY] = NUM_W'(s7_q.ax) << (2 * FRAC_BITS);
    div_num[ENT_DRATE_DX]    = NUM_W'(s7_q.ayk) << FRAC_BITS;
    div_num[ENT_DRATE_DY]    = NUM_W'(s7_q.axk) << FRAC_BITS;

    div_den[ENT_DRANGE_DX]   = DEN_W'(r7_q);
    div_den[ENT_DRANGE_DY]   = DEN_W'(r7_q);
    div_den[ENT_DBEARING_DX] = DEN_W'(s7_q.c);
    div_den[ENT_DBEARING_DY] = DEN_W'(s7_q.c);
    div_den[ENT_DRATE_DX]    = cr7_q;
    div_den[ENT_DRATE_DY]    = cr7_q;

    flg7.err                  = s7_q.err;
    flg7.neg[ENT_DRANGE_DX]   = s7_q.nx;
    flg7.neg[ENT_DRANGE_DY]   = s7_q.ny;
    flg7.neg[ENT_DBEARING_DX] = !s7_q.ny && (s7_q.ay != '0);
    flg7.neg[ENT_DBEARING_DY] = s7_q.nx;
    flg7.neg[ENT_DRATE_DX]    = s7_q.ny ^ s7_q.nk;
    flg7.neg[ENT_DRATE_DY]    = !(s7_q.nx ^ s7_q.nk);
  end

  for (genvar e = 0; e < NUM_ENT; e++) begin : g_div
    rmj_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (div_num[e]),
      .den_i (div_den[e]),
      .quo_o (div_quo[e]),
      .ovf_o (div_ovf[e])
    );
  end

  // Delay signs and error flag alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      flg_q[0] <= flg7;
      for (int i = 1; i < DIV_LAT; i++) begin
        flg_q[i] <= flg_q[i-1];
      end
    end
  end

  // Output register: saturate, sign and zero on range error
  logic [DATA_W-1:0] ent_q [NUM_ENT];
  logic              err_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int e = 0; e < NUM_ENT; e++) begin
        ent_q[e] <= sat_entry(div_quo[e], div_ovf[e], flg_q[DIV_LAT-1].neg[e],
                              flg_q[DIV_LAT-1].err);
      end
      err_q <= flg_q[DIV_LAT-1].err;
    end
  end

  assign valid_o       = vld_q[PIPE_DEPTH-1];
  assign drange_dx_o   = ent_q[ENT_DRANGE_DX];
  assign drange_dy_o   = ent_q[ENT_DRANGE_DY];
  assign dbearing_dx_o = ent_q[ENT_DBEARING_DX];
  assign dbearing_dy_o = ent_q[ENT_DBEARING_DY];
  assign drate_dx_o    = ent_q[ENT_DRATE_DX];
  assign drate_dy_o    = ent_q[ENT_DRATE_DY];
  assign range_error_o = err_q;

  // A refused request carries six zero entries
  `RMJ_ASSERT(a_err_zero, clk_i, rst_ni, valid_o && range_error_o |-> drange_dx_o == '0 && drange_dy_o == '0 && dbearing_dx_o == '0 && dbearing_dy_o == '0 && drate_dx_o == '0 && drate_dy_o == '0, "range error with nonzero entries")
  // A positive drange_dx never saturates into a negative value
  `RMJ_ASSERT(a_pos_sign, clk_i, rst_ni, en && vld_q[PIPE_DEPTH-2] && !flg_q[DIV_LAT-1].err && !flg_q[DIV_LAT-1].neg[ENT_DRANGE_DX] |=> !drange_dx_o[DATA_W-1], "drange_dx sign flipped")
  // A held pipeline keeps its occupancy
  `RMJ_ASSERT(a_hold_vld, clk_i, rst_ni, stall_o |=> $stable(vld_q), "pipeline moved while stalled")
  // Reset empties the output
  `RMJ_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !valid_o, "result valid after reset")

endmodule

// ===== hw/rtl/rmj_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmj_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rmj_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rmj_pkg::PROD_W-1:0]  rad_i,
  output logic [rmj_pkg::ROOT_W-1:0]  root_o
);
  import rmj_pkg::*;

  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W-1];
  logic [PROD_W-1:0] rad_q  [ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    logic [PROD_W-1:0] rad_in;
    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  trial;
    logic              ge;

    // Select the stage source: the input port or the previous stage
    if (k == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign cand  = {rem_in, rad_in[PROD_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_in, 2'b01});
    assign ge    = cand >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
      end
    end

    // Carry remainder and radicand to the next step
    if (k < ROOT_W - 1) begin : g_carry
      logic [REM_W+1:0] diff;
      assign diff = cand - trial;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
          rad_q[k] <= {rad_in[PROD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

// ===== hw/rtl/rmj_div.sv =====
// ----------------------------------------------------------------------------
// rmj_div
// Pipelined restoring divider with a QUO_W bit quotient and an overflow flag.
// ----------------------------------------------------------------------------
module rmj_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rmj_pkg::NUM_W-1:0]  num_i,
  input  logic [rmj_pkg::DEN_W-1:0]  den_i,
  output logic [rmj_pkg::QUO_W-1:0]  quo_o,
  output logic                       ovf_o
);
  import rmj_pkg::*;

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] lo_q  [QUO_W+1];
  logic             ovf_q [QUO_W+1];

  // Entry: flag quotients of QUO_W+1 bits or more, load the upper dividend
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= (num_i >> QUO_W) >= NUM_W'(den_i);
      rem_q[0] <= DEN_W'(num_i >> QUO_W);
      lo_q[0]  <= num_i[QUO_W-1:0];
      den_q[0] <= den_i;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W:0] cand;
    logic [DEN_W:0] diff;
    logic           ge;

    // Shift in the next dividend bit and subtract where it fits
    assign cand = {rem_q[k], lo_q[k][QUO_W-1]};
    assign diff = cand - {1'b0, den_q[k]};
    assign ge   = cand >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[k+1]  <= {lo_q[k][QUO_W-2:0], ge};
        ovf_q[k+1] <= ovf_q[k];
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign quo_o = lo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

// ===== sim/rmj_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmj_checker
// Watches both channels of the radar measurement Jacobian core, predicts the
// Jacobian entries of every taken request and compares them, in order, with
// the results that leave the core.
// ----------------------------------------------------------------------------
module rmj_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rmj_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  logic                              valid_i,
  input  logic                              stall_o,
  input  logic signed [rmj_pkg::DATA_W-1:0] pos_x_i,
  input  logic signed [rmj_pkg::DATA_W-1:0] pos_y_i,
  input  logic signed [rmj_pkg::DATA_W-1:0] vel_x_i,
  input  logic signed [rmj_pkg::DATA_W-1:0] vel_y_i,
  input  logic                              valid_o,
  input  logic                              stall_i,
  input  logic signed [rmj_pkg::DATA_W-1:0] drange_dx_o,
  input  logic signed [rmj_pkg::DATA_W-1:0] drange_dy_o,
  input  logic signed [rmj_pkg::DATA_W-1:0] dbearing_dx_o,
  input  logic signed [rmj_pkg::DATA_W-1:0] dbearing_dy_o,
  input  logic signed [rmj_pkg::DATA_W-1:0] drate_dx_o,
  input  logic signed [rmj_pkg::DATA_W-1:0] drate_dy_o,
  input  logic                              range_error_o,
  output int                                fail_count,
  output int                                jac_pending
);
  localparam int W = rmj_pkg::DATA_W;
  localparam int F = rmj_pkg::FRAC_BITS;

  typedef struct packed {
    logic [W-1:0] drange_dx;
    logic [W-1:0] drange_dy;
    logic [W-1:0] dbearing_dx;
    logic [W-1:0] dbearing_dy;
    logic [W-1:0] drate_dx;
    logic [W-1:0] drate_dy;
    logic         range_error;
  } jacobian_t;

  jacobian_t    jac_queue[$];
  logic [W-1:0] min_range_sq;

  // Floor square root, one result bit per step
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] one;
    res = '0;
    one = 64'd1 << 62;
    while (one > v) one = one >> 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v   = v - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  // Truncated quotient, saturated to the signed field, then signed
  function automatic logic [W-1:0] sat_quot(logic [127:0] num, logic [127:0] den,
                                            logic neg);
    logic [127:0] q;
    logic [127:0] lim;
    q   = num / den;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) q = lim;
    return neg ? W'(-q) : W'(q);
  endfunction

  function automatic jacobian_t jacobian(logic signed [W-1:0] x, logic signed [W-1:0] y,
                                         logic signed [W-1:0] vx, logic signed [W-1:0] vy,
                                         logic [W-1:0] thr);
    jacobian_t         j;
    logic signed [65:0] sx, sy, svx, svy, k;
    logic [63:0]       ax, ay, c, r, kmag;
    logic              nx, ny, nk;
    sx  = x;
    sy  = y;
    svx = vx;
    svy = vy;
    nx  = x < 0;
    ny  = y < 0;
    ax  = nx ? 64'(-sx) : 64'(sx);
    ay  = ny ? 64'(-sy) : 64'(sy);
    c   = ax * ax + ay * ay;
    j   = '0;
    // Refuse the division when the range is too small
    if (c == 0 || c < (64'(thr) << F)) begin
      j.range_error = 1'b1;
      return j;
    end
    k    = svx * sy - svy * sx;
    nk   = k < 0;
    kmag = nk ? 64'(-k) : 64'(k);
    r    = int_sqrt(c);
    j.drange_dx   = sat_quot(128'(ax) << F, 128'(r), nx);
    j.drange_dy   = sat_quot(128'(ay) << F, 128'(r), ny);
    j.dbearing_dx = sat_quot(128'(ay) << (2 * F), 128'(c), !ny && ay != 0);
    j.dbearing_dy = sat_quot(128'(ax) << (2 * F), 128'(c), nx);
    j.drate_dx    = sat_quot((128'(ay) * 128'(kmag)) << F, 128'(c) * 128'(r),
                             ny != nk);
    j.drate_dy    = sat_quot((128'(ax) * 128'(kmag)) << F, 128'(c) * 128'(r),
                             nx == nk);
    return j;
  endfunction

  // Track the threshold register
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_sq <= rmj_pkg::MIN_RANGE_SQ_RESET;
    end else if (cfg_we_i) begin
      min_range_sq <= cfg_wdata_i;
    end
  end

  // Predict taken requests, compare taken results
  initial fail_count = 0;
  always @(posedge clk_i) begin
    jacobian_t   exp_j;
    jacobian_t   got_j;
    logic [W-1:0] ev[7];
    logic [W-1:0] av[7];
    string       nm[7];
    if (rst_ni) begin
      if (valid_i && !stall_o)
        jac_queue.push_back(jacobian(pos_x_i, pos_y_i, vel_x_i, vel_y_i, min_range_sq));
      if (valid_o && !stall_i) begin
        if (jac_queue.size() == 0) begin
          $display("%0t: result with no request waiting", $time);
          fail_count = fail_count + 1;
        end else begin
          exp_j = jac_queue.pop_front();
          got_j = '{drange_dx_o, drange_dy_o, dbearing_dx_o, dbearing_dy_o,
                    drate_dx_o, drate_dy_o, range_error_o};
          nm = '{"drange_dx", "drange_dy", "dbearing_dx", "dbearing_dy",
                 "drate_dx", "drate_dy", "range_error"};
          ev = '{exp_j.drange_dx, exp_j.drange_dy, exp_j.dbearing_dx, exp_j.dbearing_dy,
                 exp_j.drate_dx, exp_j.drate_dy, W'(exp_j.range_error)};
          av = '{got_j.drange_dx, got_j.drange_dy, got_j.dbearing_dx, got_j.dbearing_dy,
                 got_j.drate_dx, got_j.drate_dy, W'(got_j.range_error)};
          for (int i = 0; i < 7; i++) begin
            if (ev[i] !== av[i]) begin
              $display("%0t: %s expected %h actual %h", $time, nm[i], ev[i], av[i]);
              fail_count = fail_count + 1;
            end
          end
        end
      end
    end
    jac_pending = jac_queue.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the radar measurement Jacobian core through several threshold
// settings with directed and random states, bursty requests and a stalling
// receiver, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;
  localparam int W         = rmj_pkg::DATA_W;
  localparam int DRAIN     = 100;
  localparam int CYC_LIMIT = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [W-1:0]        cfg_wdata_i = '0;
  logic                valid_i = 1'b0;
  logic                stall_o;
  logic signed [W-1:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic                valid_o;
  logic                stall_i = 1'b0;
  logic signed [W-1:0] drange_dx_o, drange_dy_o, dbearing_dx_o, dbearing_dy_o;
  logic signed [W-1:0] drate_dx_o, drate_dy_o;
  logic                range_error_o;
  int                  fail_count, jac_pending;
  int                  cycles = 0;
  int                  stall_mode = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  radar_measurement_jacobian_core u_top (.*);

  rmj_checker u_chk (.*);

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver stall pattern: switch mode now and then
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: stall_i <= 1'b0;
      1: stall_i <= ($urandom_range(0, 9) < 3);
      2: stall_i <= (cycles % 7) < 3;
      default: stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  function automatic logic [W-1:0] rand_field();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: return W'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
      3: return W'($signed($urandom_range(0, 2000)) - 1000);
      4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 15)
                                     : 32'h8000_0000 + $urandom_range(0, 15);
      default: return W'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000);
    endcase
  endfunction

  // Present one request and hold it until taken
  task automatic send_req(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] vx,
                          logic [W-1:0] vy);
    valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    vel_x_i <= vx;
    vel_y_i <= vy;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic end_burst(int gap);
    valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [W-1:0] v);
    while (jac_pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_reqs(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_req(rand_field(), rand_field(), rand_field(), rand_field());
        left--;
      end
      end_burst($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [W-1:0] thr_list[5];
    thr_list = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, $urandom(), 32'h0000_0007};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset threshold, then extremes and the small range boundary
    send_req(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(1, 0, 5, 5);
    send_req(677, 0, 0, 0);
    send_req(678, 0, 32'h0001_0000, 0);
    send_req(0, 678, 0, 32'h0001_0000);
    send_req(32'h0001_0000, 0, 0, 32'h0001_0000);
    send_req(0, 32'hFFFF_0000, 32'h0001_0000, 0);
    end_burst(3);
    send_req(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(32'h8000_0000, 0, 0, 32'h8000_0000);
    send_req(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_req(32'h0000_0300, 32'hFFFF_FD00, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFE_0000);
    end_burst(2);

    // Threshold sweep with random states in each setting
    foreach (thr_list[p]) begin
      write_threshold(thr_list[p]);
      if (p == 1) send_req(32'h8000_0000, 32'h8000_0000, 1, 1);
      random_reqs(150);
    end

    while (jac_pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0 && jac_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
